// File: design/cc_pkg.sv
// ChaCha20 stream unit package: shared types, constants and register indexes.
// No dependencies.
package cc_pkg;

  localparam int unsigned WordBits  = 64;
  localparam int unsigned WordBytes = 8;
  localparam int unsigned BlockBits = 512;

  localparam logic [31:0] Sigma0 = 32'h6170_7865;
  localparam logic [31:0] Sigma1 = 32'h3320_646e;
  localparam logic [31:0] Sigma2 = 32'h7962_2d32;
  localparam logic [31:0] Sigma3 = 32'h6b20_6574;

  localparam logic [2:0] RegKeyA    = 3'd0;
  localparam logic [2:0] RegKeyB    = 3'd1;
  localparam logic [2:0] RegKeyC    = 3'd2;
  localparam logic [2:0] RegKeyD    = 3'd3;
  localparam logic [2:0] RegNonceLo = 3'd4;
  localparam logic [2:0] RegNonceHi = 3'd5;
  localparam logic [2:0] RegInitCtr = 3'd6;

  typedef logic [15:0][31:0] cc_state_t;

  typedef struct packed {
    logic start;
    logic abort;
  } cc_core_ctl_t;

endpackage

// File: design/cc_stream_if.sv
// Valid/ready channels carrying the input and result items.
// Depends on nothing.
interface cc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_in;
  logic [3:0]  byte_count;
  logic        last_item;
  modport source (output valid, data_in, byte_count, last_item, input ready);
  modport sink   (input valid, data_in, byte_count, last_item, output ready);
endinterface

interface cc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;
  logic [3:0]  byte_count_out;
  logic        last_out;
  modport source (output valid, data_out, byte_count_out, last_out, input ready);
  modport sink   (input valid, data_out, byte_count_out, last_out, output ready);
endinterface

// File: design/cc_qround.sv
// One ChaCha quarter-round lane (combinational).
// Depends on cc_pkg only by convention; no imports.
module cc_qround (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);
  logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2, t;

  always_comb begin
    a1 = a_i + b_i;
    t  = d_i ^ a1;
    d1 = {t[15:0], t[31:16]};
    c1 = c_i + d1;
    t  = b_i ^ c1;
    b1 = {t[19:0], t[31:20]};
    a2 = a1 + b1;
    t  = d1 ^ a2;
    d2 = {t[23:0], t[31:24]};
    c2 = c1 + d2;
    t  = b1 ^ c2;
    b2 = {t[24:0], t[31:25]};
  end

  assign a_o = a2;
  assign b_o = b2;
  assign c_o = c2;
  assign d_o = d2;
endmodule

// File: design/cc_core.sv
// Block function: four quarter-round lanes, one half double-round per cycle,
// then a merge stage adding back the input state. Depends on cc_pkg, cc_qround.
module cc_core #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cc_pkg::cc_core_ctl_t      ctl_i,
  input  cc_pkg::cc_state_t         init_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [cc_pkg::BlockBits-1:0] block_o
);
  localparam int unsigned Rounds = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RW     = $clog2(Rounds + 1);

  cc_pkg::cc_state_t w_q, w_d, init_q;
  logic [RW-1:0]     rnd_q;
  logic              busy_q, done_q;
  logic [cc_pkg::BlockBits-1:0] block_q;
  logic [3:0][31:0]  la, lb, lc, ld, oa, ob, oc, od;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    cc_qround u_qr (
      .a_i(la[k]), .b_i(lb[k]), .c_i(lc[k]), .d_i(ld[k]),
      .a_o(oa[k]), .b_o(ob[k]), .c_o(oc[k]), .d_o(od[k])
    );
  end

  // even rounds: columns, odd rounds: diagonals
  always_comb begin
    w_d = w_q;
    for (int k = 0; k < 4; k++) begin
      la[k] = w_q[k];
      lb[k] = rnd_q[0] ? w_q[4 + ((k + 1) % 4)]  : w_q[4 + k];
      lc[k] = rnd_q[0] ? w_q[8 + ((k + 2) % 4)]  : w_q[8 + k];
      ld[k] = rnd_q[0] ? w_q[12 + ((k + 3) % 4)] : w_q[12 + k];
    end
    for (int k = 0; k < 4; k++) begin
      w_d[k] = oa[k];
      if (rnd_q[0]) begin
        w_d[4 + ((k + 1) % 4)]  = ob[k];
        w_d[8 + ((k + 2) % 4)]  = oc[k];
        w_d[12 + ((k + 3) % 4)] = od[k];
      end else begin
        w_d[4 + k]  = ob[k];
        w_d[8 + k]  = oc[k];
        w_d[12 + k] = od[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.abort) begin
        busy_q <= 1'b0;
      end else if (ctl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == RW'(Rounds)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          rnd_q <= rnd_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start && !busy_q) begin
      w_q    <= init_i;
      init_q <= init_i;
    end else if (busy_q && rnd_q != RW'(Rounds)) begin
      w_q <= w_d;
    end
    if (busy_q && rnd_q == RW'(Rounds)) begin
      for (int i = 0; i < 16; i++) begin
        block_q[i*32 +: 32] <= w_q[i] + init_q[i];
      end
    end
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign block_o = block_q;
endmodule

// File: design/chacha20_stream_xor_unit.sv
// ChaCha20 stream XOR unit: a request is registered at its accept edge and the result
// can leave in the next cycle. Each block serves 8 words, and throughput is set by the
// one-round-per-cycle datapath; the next block is built while the current one is used.
// After a last word the prebuilt block is dropped and the next message's first block is
// built anew. Reset clears control state; key, nonce and counter reset to zero.
module chacha20_stream_xor_unit #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  cc_in_if.sink       in_i,
  cc_out_if.source    out_o
);
  // configuration
  logic [3:0][63:0] key_q;
  logic [63:0]      nonce_lo_q;
  logic [31:0]      nonce_hi_q, init_ctr_q;

  // stream state
  logic [31:0]  ctr_q;           // counter of the next block the core builds
  logic [2:0]   pos_q;           // word slot within current block
  logic         nxt_valid_q;     // core output holds an unused block
  logic [cc_pkg::BlockBits-1:0] ks_q;

  logic         out_valid_q;
  logic [63:0]  out_data_q;
  logic [3:0]   out_cnt_q;
  logic         out_last_q;

  cc_pkg::cc_core_ctl_t ctl;
  cc_pkg::cc_state_t    init_st;
  logic                 core_busy, core_done;
  logic [cc_pkg::BlockBits-1:0] core_block;

  logic        in_acc, flush;
  logic [63:0] ks_word, mask;
  logic [3:0]  nbytes;

  // a request needs a block only at slot zero; otherwise the held block serves
  assign in_i.ready = (!out_valid_q || out_o.ready) && (pos_q != 3'd0 || nxt_valid_q);
  assign in_acc     = in_i.valid && in_i.ready;

  // last word or config change: any prebuilt block is stale
  assign flush = cfg_we_i || (in_acc && in_i.last_item);

  assign ctl.abort = flush;
  assign ctl.start = !nxt_valid_q && !core_busy && !core_done && !flush;

  always_comb begin
    init_st[0]  = cc_pkg::Sigma0;
    init_st[1]  = cc_pkg::Sigma1;
    init_st[2]  = cc_pkg::Sigma2;
    init_st[3]  = cc_pkg::Sigma3;
    for (int i = 0; i < 4; i++) begin
      init_st[4 + 2*i] = key_q[i][31:0];
      init_st[5 + 2*i] = key_q[i][63:32];
    end
    init_st[12] = ctr_q;
    init_st[13] = nonce_lo_q[31:0];
    init_st[14] = nonce_lo_q[63:32];
    init_st[15] = nonce_hi_q;
  end

  cc_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .init_i  (init_st),
    .busy_o  (core_busy),
    .done_o  (core_done),
    .block_o (core_block)
  );

  // slot zero reads the fresh block straight from the core
  always_comb begin
    ks_word = (pos_q == 3'd0) ? core_block[63:0] : ks_q[pos_q*64 +: 64];
    nbytes  = (in_i.byte_count > 4'd8) ? 4'd8 : in_i.byte_count;
    for (int i = 0; i < cc_pkg::WordBytes; i++) begin
      mask[i*8 +: 8] = (4'(i) < nbytes) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      init_ctr_q  <= '0;
      ctr_q       <= '0;
      pos_q       <= '0;
      nxt_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cc_pkg::RegKeyA:    key_q[0]   <= cfg_data_i;
          cc_pkg::RegKeyB:    key_q[1]   <= cfg_data_i;
          cc_pkg::RegKeyC:    key_q[2]   <= cfg_data_i;
          cc_pkg::RegKeyD:    key_q[3]   <= cfg_data_i;
          cc_pkg::RegNonceLo: nonce_lo_q <= cfg_data_i;
          cc_pkg::RegNonceHi: nonce_hi_q <= cfg_data_i[31:0];
          cc_pkg::RegInitCtr: init_ctr_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end

      if (out_o.ready) out_valid_q <= 1'b0;
      if (in_acc) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_q + 3'd1;
      end

      // block hand-off and counter bookkeeping
      if (flush) begin
        nxt_valid_q <= 1'b0;
        if (in_acc) pos_q <= '0;
        if (cfg_we_i && cfg_idx_i == cc_pkg::RegInitCtr) ctr_q <= cfg_data_i[31:0];
        else                                             ctr_q <= init_ctr_q;
      end else begin
        if (core_done) begin
          nxt_valid_q <= 1'b1;
          ctr_q       <= ctr_q + 32'd1;
        end
        if (in_acc && pos_q == 3'd0) nxt_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= (in_i.data_in ^ ks_word) & mask;
      out_cnt_q  <= in_i.byte_count;
      out_last_q <= in_i.last_item;
      if (pos_q == 3'd0) ks_q <= core_block;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data_out       = out_data_q;
  assign out_o.byte_count_out = out_cnt_q;
  assign out_o.last_out       = out_last_q;

  // a new block never lands while an unused one is held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> !$past(nxt_valid_q))
    else $error("core finished over a held block");

  // a request at slot zero always has a block behind it
  a_block_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pos_q == 3'd0) |-> nxt_valid_q)
    else $error("slot zero request without keystream block");

  // the core is never started while a block waits
  a_no_spec_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nxt_valid_q |-> !ctl.start)
    else $error("core started with a block pending");
endmodule

// File: verif/chacha20_stream_xor_checker.sv
// Checker for the ChaCha20 stream XOR unit: watches the config port and both
// channels, predicts each result word and compares. Depends on cc_pkg.
`timescale 1ns / 100ps
module chacha20_stream_xor_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] in_data_i,
  input  logic [3:0]  in_count_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] out_data_i,
  input  logic [3:0]  out_count_i,
  input  logic        out_last_i,
  output int          errors_o,
  output int          pending_o
);
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } word_t;

  logic [63:0] key_q [4];
  logic [63:0] nonce_lo_q;
  logic [31:0] nonce_hi_q, init_ctr_q, blk_ctr_q;
  logic [511:0] ks_q;
  int unsigned slot_q;
  bit in_msg_q;
  word_t expected_words[$];

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void qround(ref logic [31:0] s[16], input int a, b, c, d);
    s[a] += s[b]; s[d] = rotl(s[d] ^ s[a], 16);
    s[c] += s[d]; s[b] = rotl(s[b] ^ s[c], 12);
    s[a] += s[b]; s[d] = rotl(s[d] ^ s[a], 8);
    s[c] += s[d]; s[b] = rotl(s[b] ^ s[c], 7);
  endfunction

  function automatic logic [511:0] keystream_block(logic [31:0] ctr);
    logic [31:0] st[16], w[16];
    logic [511:0] blk;
    st[0] = cc_pkg::Sigma0; st[1] = cc_pkg::Sigma1;
    st[2] = cc_pkg::Sigma2; st[3] = cc_pkg::Sigma3;
    for (int k = 0; k < 4; k++) begin
      st[4 + 2 * k] = key_q[k][31:0];
      st[5 + 2 * k] = key_q[k][63:32];
    end
    st[12] = ctr; st[13] = nonce_lo_q[31:0]; st[14] = nonce_lo_q[63:32];
    st[15] = nonce_hi_q;
    w = st;
    for (int r = 0; r < 10; r++) begin
      qround(w, 0, 4, 8, 12); qround(w, 1, 5, 9, 13);
      qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
      qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
      qround(w, 2, 7, 8, 13); qround(w, 3, 4, 9, 14);
    end
    // words little-endian, word 0 in the low bits
    for (int k = 0; k < 16; k++) blk[k * 32 +: 32] = w[k] + st[k];
    return blk;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_t got, exp_w;
    int unsigned nvalid;
    if (!rst_ni) begin
      foreach (key_q[k]) key_q[k] = '0;
      nonce_lo_q = '0; nonce_hi_q = '0; init_ctr_q = '0; blk_ctr_q = '0;
      slot_q = 0; in_msg_q = 0; ks_q = '0;
      expected_words.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cc_pkg::RegKeyA: key_q[0] = cfg_data_i;
          cc_pkg::RegKeyB: key_q[1] = cfg_data_i;
          cc_pkg::RegKeyC: key_q[2] = cfg_data_i;
          cc_pkg::RegKeyD: key_q[3] = cfg_data_i;
          cc_pkg::RegNonceLo: nonce_lo_q = cfg_data_i;
          cc_pkg::RegNonceHi: nonce_hi_q = cfg_data_i[31:0];
          cc_pkg::RegInitCtr: init_ctr_q = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (!in_msg_q) begin
          blk_ctr_q = init_ctr_q;
          slot_q = 0;
        end
        if (slot_q == 0) begin
          ks_q = keystream_block(blk_ctr_q);
          blk_ctr_q++;
        end
        nvalid = (in_count_i > 8) ? 8 : in_count_i;
        exp_w.data = '0;
        for (int b = 0; b < 8; b++)
          if (b < nvalid) exp_w.data[b * 8 +: 8] = in_data_i[b * 8 +: 8] ^ ks_q[(slot_q * 8 + b) * 8 +: 8];
        exp_w.count = in_count_i;
        exp_w.last = in_last_i;
        expected_words.push_back(exp_w);
        slot_q = (slot_q + 1) % 8;
        in_msg_q = 1;
        if (in_last_i) begin
          in_msg_q = 0; slot_q = 0; blk_ctr_q = init_ctr_q;
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = '{out_data_i, out_count_i, out_last_i};
        if (expected_words.size() == 0) begin
          $error("result word with none expected: data %h", got.data);
          errors_o++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got.data !== exp_w.data) begin
            $error("data_out: expected %h, got %h", exp_w.data, got.data); errors_o++;
          end
          if (got.count !== exp_w.count) begin
            $error("byte_count_out: expected %0d, got %0d", exp_w.count, got.count);
            errors_o++;
          end
          if (got.last !== exp_w.last) begin
            $error("last_out: expected %0b, got %0b", exp_w.last, got.last); errors_o++;
          end
        end
      end
    end
    pending_o = expected_words.size();
  end
endmodule

// File: verif/chacha20_stream_xor_unit_tb.sv
// Testbench top for chacha20_stream_xor_unit: drives config writes and message
// words with random idling; checking lives in chacha20_stream_xor_checker.
`timescale 1ns / 100ps
module chacha20_stream_xor_unit_tb;
  localparam int WatchdogLimit = 20000;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [2:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  int errors, pending, idle_cycles;
  int src_idle_pct, snk_idle_pct;
  bit timed_out;

  cc_in_if in_ch();
  cc_out_if out_ch();

  initial begin
    in_ch.valid = 0; in_ch.data_in = '0; in_ch.byte_count = 4'd8; in_ch.last_item = 0;
    out_ch.ready = 0;
  end

  chacha20_stream_xor_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_i(in_ch), .out_o(out_ch)
  );

  chacha20_stream_xor_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .in_data_i(in_ch.data_in),
    .in_count_i(in_ch.byte_count), .in_last_i(in_ch.last_item),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_i(out_ch.data_out),
    .out_count_i(out_ch.byte_count_out), .out_last_i(out_ch.last_out),
    .errors_o(errors), .pending_o(pending)
  );

  initial forever #5 clk_i = ~clk_i;

  // receiver stalls at random
  always @(posedge clk_i)
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

  // watchdog: cycles with no request or result accepted
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // wait until all results are in, plus margin for a block still being built
  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic load_config(logic [63:0] fill, logic [31:0] ctr);
    write_reg(cc_pkg::RegKeyA, fill ^ {$urandom, $urandom});
    write_reg(cc_pkg::RegKeyB, fill ^ {$urandom, $urandom});
    write_reg(cc_pkg::RegKeyC, fill ^ {$urandom, $urandom});
    write_reg(cc_pkg::RegKeyD, fill ^ {$urandom, $urandom});
    write_reg(cc_pkg::RegNonceLo, fill ^ {$urandom, $urandom});
    write_reg(cc_pkg::RegNonceHi, {32'h0, fill[31:0] ^ $urandom});
    write_reg(cc_pkg::RegInitCtr, {32'h0, ctr});
  endtask

  // one request; valid stays up across back-to-back requests and is dropped
  // by the idle loop or by the caller
  task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1; in_ch.data_in <= data; in_ch.byte_count <= cnt;
    in_ch.last_item <= last;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_message(int nwords, bit odd_counts);
    logic [3:0] cnt;
    for (int w = 0; w < nwords; w++) begin
      cnt = 4'd8;
      if (w == nwords - 1) cnt = $urandom_range(1, 8);
      if (odd_counts) cnt = $urandom_range(0, 15);
      send_word({$urandom, $urandom}, cnt, w == nwords - 1);
    end
  endtask

  initial begin
    int sent;
    src_idle_pct = 0; snk_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset config (all zero), extremes of data and counts
    send_word('0, 4'd8, 0);
    send_word('1, 4'd8, 0);
    send_word(64'h0123_4567_89ab_cdef, 4'd0, 0);
    send_word('1, 4'd15, 0);
    send_word('1, 4'd3, 0);
    for (int k = 0; k < 5; k++) send_word({$urandom, $urandom}, 4'd8, 0);
    send_word('1, 4'd5, 1);
    drain();
    // all-ones config, counter wraps inside the message
    load_config('1, 32'hFFFF_FFFF);
    write_reg(cc_pkg::RegKeyA, '1); write_reg(cc_pkg::RegKeyB, '1);
    write_reg(cc_pkg::RegKeyC, '1);
    write_reg(cc_pkg::RegKeyD, '1); write_reg(cc_pkg::RegNonceLo, '1);
    write_reg(cc_pkg::RegNonceHi, 64'hFFFF_FFFF);
    for (int k = 0; k < 17; k++) send_word({$urandom, $urandom}, 4'd8, k == 16);
    drain();
    // one-word messages
    send_word('0, 4'd1, 1);
    send_word('1, 4'd8, 1);
    drain();

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 76 : 0;
      snk_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 8 : 0;
      for (int s = 0; s < 5; s++) begin
        load_config(s[0] ? '0 : '1, (s == 2) ? 32'hFFFF_FFFE : $urandom);
        for (int m = 0; m < 15; m++) begin
          int n;
          n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
          send_message(n, $urandom_range(9) == 0);
          sent += n;
          // pause until everything is back once per setting
          if (m == 4) begin
            in_ch.valid <= 0;
            while (pending != 0) @(posedge clk_i);
          end
        end
        drain();
      end
    end

    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: chacha20_stream_xor_unit.f
design/cc_pkg.sv
design/cc_stream_if.sv
design/cc_qround.sv
design/cc_core.sv
design/chacha20_stream_xor_unit.sv
verif/chacha20_stream_xor_checker.sv
verif/chacha20_stream_xor_unit_tb.sv
